// ----- hdl/mbps_pkg.sv -----
// Shared types, constants and helpers for the masked byte pattern search unit.
package mbps_pkg;

	// Longest pattern that the unit compares; the window has one cell per byte.
	localparam int MAX_PATTERN = 32;
	localparam int PAT_LIMIT   = (MAX_PATTERN < 32) ? MAX_PATTERN : 32;
	localparam int WIN_DEPTH   = PAT_LIMIT;

	// Width of the saturating byte counter.
	localparam int COUNT_BITS = 32;

	// Fixed field widths.
	localparam int BYTE_W    = 8;
	localparam int LEN_W     = 6;
	localparam int ADDR_W    = 64;
	localparam int MASK_W    = 32;
	localparam int PAT_W     = 256;
	localparam int POS_W     = 5;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 64;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_0,
		REG_PATTERN_1,
		REG_PATTERN_2,
		REG_PATTERN_3,
		REG_CARE_MASK,
		REG_PATTERN_LENGTH,
		REG_BASE_ADDRESS
	} cfg_reg_t;

	// Per-cell control from the top level.
	typedef struct packed {
		logic shift;
		logic check;
	} cell_ctl_t;

	// Pick pattern byte j out of the flattened pattern words.
	function automatic logic [BYTE_W-1:0] pat_byte(input logic [PAT_W-1:0] pat,
	                                                input logic [POS_W-1:0] j);
		return pat[{j, 3'b000} +: BYTE_W];
	endfunction

endpackage

// ----- hdl/mbps_cell.sv -----
// One window cell: holds one byte, passes it on and compares the byte it takes.
module mbps_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mbps_pkg::cell_ctl_t          ctl,
	input  logic [mbps_pkg::BYTE_W-1:0]  prev_byte,
	input  logic [mbps_pkg::BYTE_W-1:0]  pat,
	output logic [mbps_pkg::BYTE_W-1:0]  cur_byte,
	output logic                         ok
);

	logic [mbps_pkg::BYTE_W-1:0] byte_q;

	// The cell matches when it is a wildcard or its next byte equals the pattern byte.
	assign ok       = !ctl.check || (prev_byte == pat);
	assign cur_byte = byte_q;

	// Take the neighbor's byte on every transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (ctl.shift) begin
			byte_q <= prev_byte;
		end
	end

endmodule

// ----- hdl/masked_byte_pattern_search_unit.sv -----
// Top level of the masked byte pattern search unit: config, cell chain and result register.
//
//  channel   direction  handshake                      payload
//  s_axis    in         s_axis_tvalid / s_axis_tready  tdata: data_byte; tuser: region_start;
//                                                      tlast: region_end
//  m_axis    out        m_axis_tvalid / m_axis_tready  tdata: hit_address, first_address;
//                                                      tuser: hit, found; tlast: scan_done
//  cfg       in         cfg_we                         cfg_index, cfg_data
//
// One byte is taken per cycle while s_axis_tready is high; its result is registered in the cycle after.
// All window cells compare in parallel in the cycle of the transfer, so the rate is set by
// the single output register, which accepts a new byte in the cycle its result is taken.
// Reset clears the window, the byte count, the match flag and the configuration registers, with length set to one.
// s_axis_tready is low only while a result sits in the output register and is not taken.
module masked_byte_pattern_search_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	// Configuration write port.
	input  logic                            cfg_we,
	input  logic [mbps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mbps_pkg::CFG_W-1:0]      cfg_data,
	// Input stream.
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [7:0]                      s_axis_tdata,   // [7:0] data_byte
	input  logic                            s_axis_tuser,   // [0] region_start
	input  logic                            s_axis_tlast,   // region_end
	// Result stream.
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [127:0]                    m_axis_tdata,   // [63:0] hit_address,
	                                                        // [127:64] first_address
	output logic [1:0]                      m_axis_tuser,   // [0] hit, [1] found
	output logic                            m_axis_tlast    // scan_done
);

	localparam int WD = mbps_pkg::WIN_DEPTH;
	localparam int CB = mbps_pkg::COUNT_BITS;
	localparam logic [CB-1:0] COUNT_MAX = '1;

	// Configuration registers.
	logic [mbps_pkg::PAT_W-1:0]   pattern_q;
	logic [mbps_pkg::MASK_W-1:0]  care_q;
	logic [mbps_pkg::LEN_W-1:0]   length_q;
	logic [mbps_pkg::ADDR_W-1:0]  base_q;

	// Region state.
	logic [CB-1:0]                count_q;
	logic                         seen_q;
	logic [mbps_pkg::ADDR_W-1:0]  first_q;

	// Result register.
	logic                         out_valid_q;
	logic                         hit_q;
	logic [mbps_pkg::ADDR_W-1:0]  hit_addr_q;
	logic                         found_q;
	logic [mbps_pkg::ADDR_W-1:0]  first_out_q;
	logic                         done_q;

	logic                         in_fire;
	logic [mbps_pkg::LEN_W-1:0]   eff_len;
	logic [CB-1:0]                count_next;
	logic [CB-1:0]                offset;
	logic [mbps_pkg::ADDR_W-1:0]  cand_addr;
	logic [WD-1:0]                cell_ok;
	logic [WD-1:0][7:0]           win_byte;
	logic                         hit_now;
	logic                         seen_base;
	logic [mbps_pkg::ADDR_W-1:0]  first_base;
	logic                         take_first;
	logic [mbps_pkg::ADDR_W-1:0]  first_next;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	// Configuration writes; indexes past the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
			care_q    <= '0;
			length_q  <= mbps_pkg::LEN_W'(1);
			base_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				mbps_pkg::REG_PATTERN_0:      pattern_q[63:0]    <= cfg_data;
				mbps_pkg::REG_PATTERN_1:      pattern_q[127:64]  <= cfg_data;
				mbps_pkg::REG_PATTERN_2:      pattern_q[191:128] <= cfg_data;
				mbps_pkg::REG_PATTERN_3:      pattern_q[255:192] <= cfg_data;
				mbps_pkg::REG_CARE_MASK:      care_q   <= cfg_data[mbps_pkg::MASK_W-1:0];
				mbps_pkg::REG_PATTERN_LENGTH: length_q <= cfg_data[mbps_pkg::LEN_W-1:0];
				mbps_pkg::REG_BASE_ADDRESS:   base_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Effective length: zero counts as one, anything past the window as the window.
	always_comb begin
		eff_len = length_q;
		if (length_q == '0) begin
			eff_len = mbps_pkg::LEN_W'(1);
		end else if (length_q > mbps_pkg::LEN_W'(mbps_pkg::PAT_LIMIT)) begin
			eff_len = mbps_pkg::LEN_W'(mbps_pkg::PAT_LIMIT);
		end
	end

	// Saturating byte count, restarted by a region start.
	always_comb begin
		if (s_axis_tuser) begin
			count_next = CB'(1);
		end else if (count_q == COUNT_MAX) begin
			count_next = count_q;
		end else begin
			count_next = count_q + CB'(1);
		end
	end

	// Cell chain: cell 0 takes the incoming byte, cell k compares against pattern byte
	// (length - 1 - k). A region start feeds zeros into the rest of the chain.
	genvar k;
	generate
		for (k = 0; k < WD; k++) begin : g_cell
			localparam logic [mbps_pkg::LEN_W-1:0] K = mbps_pkg::LEN_W'(k);
			logic [mbps_pkg::LEN_W-1:0] pos;
			logic [7:0]                 prev;
			mbps_pkg::cell_ctl_t        ctl;

			assign pos       = eff_len - mbps_pkg::LEN_W'(1) - K;
			assign ctl.shift = in_fire;
			assign ctl.check = (K < eff_len) && care_q[pos[mbps_pkg::POS_W-1:0]];

			if (k == 0) begin : g_head
				assign prev = s_axis_tdata;
			end else begin : g_body
				assign prev = s_axis_tuser ? 8'h00 : win_byte[k-1];
			end

			mbps_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctl       (ctl),
				.prev_byte (prev),
				.pat       (mbps_pkg::pat_byte(pattern_q, pos[mbps_pkg::POS_W-1:0])),
				.cur_byte  (win_byte[k]),
				.ok        (cell_ok[k])
			);
		end
	endgenerate

	// Match decision, start address and first-match bookkeeping.
	always_comb begin
		hit_now    = (&cell_ok) && (count_next >= CB'(eff_len));
		offset     = count_next - CB'(eff_len);
		cand_addr  = base_q + mbps_pkg::ADDR_W'(offset);
		seen_base  = s_axis_tuser ? 1'b0 : seen_q;
		first_base = s_axis_tuser ? '0 : first_q;
		take_first = hit_now && !seen_base;
		first_next = take_first ? cand_addr : first_base;
	end

	// Region state updates on each input transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			seen_q  <= 1'b0;
			first_q <= '0;
		end else if (in_fire) begin
			count_q <= count_next;
			seen_q  <= seen_base || hit_now;
			first_q <= first_next;
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload is loaded with each input transfer.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			hit_q       <= hit_now;
			hit_addr_q  <= hit_now ? cand_addr : '0;
			found_q     <= seen_base || hit_now;
			first_out_q <= first_next;
			done_q      <= s_axis_tlast;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {first_out_q, hit_addr_q};
	assign m_axis_tuser  = {found_q, hit_q};
	assign m_axis_tlast  = done_q;

endmodule

// ----- hdl/mbps_checker.sv -----
// Port-level checks for the masked byte pattern search unit, bound to the top level.
module mbps_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tready,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [127:0]                    m_axis_tdata,
	input logic [1:0]                      m_axis_tuser,
	input logic                            m_axis_tlast
);

	// A stalled result keeps its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
			&& $stable(m_axis_tlast))
		else $error("result changed while stalled");

	// The input side stalls only while a result waits to be taken.
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without a pending result");

	// A hit always counts as found.
	a_hit_found: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tuser[1])
		else $error("hit without found");

	// Without a hit the hit address reads zero.
	a_hit_addr: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[63:0] == 64'd0)
		else $error("hit address set without a hit");

	// Before any match the first address reads zero.
	a_first_addr: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tdata[127:64] == 64'd0)
		else $error("first address set before any match");

endmodule

bind masked_byte_pattern_search_unit mbps_checker u_mbps_checker (.*);

// ----- sim/masked_byte_pattern_search_unit_tb.sv -----
// Self-checking testbench for the masked byte pattern search unit with a built-in scan predictor.
`timescale 1ns / 1ps

module masked_byte_pattern_search_unit_tb;

	localparam int STALL_LIMIT  = 2000;
	localparam int HOLD_CYCLES  = 300;
	localparam int PHASE_ITEMS  = 110;
	localparam int RANDOM_PHASES = 7;

	// One byte transfer toward the block.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       region_start;
		logic       region_end;
	} scan_item_t;

	// One result transfer from the block.
	typedef struct packed {
		logic        hit;
		logic [63:0] hit_address;
		logic        found;
		logic [63:0] first_address;
		logic        scan_done;
	} scan_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                           cfg_we = 1'b0;
	logic [mbps_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [mbps_pkg::CFG_W-1:0]     cfg_data = '0;

	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [7:0]   s_axis_tdata = '0;   // [7:0] data_byte
	logic         s_axis_tuser = 1'b0; // [0] region_start
	logic         s_axis_tlast = 1'b0; // region_end
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [127:0] m_axis_tdata;        // [63:0] hit_address, [127:64] first_address
	logic [1:0]   m_axis_tuser;        // [0] hit, [1] found
	logic         m_axis_tlast;

	masked_byte_pattern_search_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// Mirror of the configuration registers.
	logic [mbps_pkg::PAT_W-1:0]  pat_flat = '0;
	logic [mbps_pkg::MASK_W-1:0] care_bits = '0;
	logic [mbps_pkg::LEN_W-1:0]  len_reg = 6'd1;
	logic [mbps_pkg::ADDR_W-1:0] base_reg = '0;

	// Mirror of the scan state; index 0 holds the newest byte.
	logic [7:0]                      win_bytes [mbps_pkg::WIN_DEPTH];
	logic [mbps_pkg::COUNT_BITS-1:0] byte_count = '0;
	logic                            match_flag = 1'b0;
	logic [mbps_pkg::ADDR_W-1:0]     first_addr = '0;

	scan_item_t   byte_queue[$];
	scan_result_t predicted_results[$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_arm = 1'b0;
	int mismatches = 0;
	int bytes_queued = 0;
	int bytes_sent = 0;
	int results_seen = 0;
	int hits_seen = 0;
	int settings_used = 0;
	int stall_cycles = 0;

	initial begin
		for (int i = 0; i < mbps_pkg::WIN_DEPTH; i++) win_bytes[i] = '0;
	end

	// Clock generation.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Length actually compared: zero acts as one, anything past the window is clipped.
	function automatic int active_length();
		int n;
		n = int'(len_reg);
		if (n == 0) n = 1;
		if (n > mbps_pkg::PAT_LIMIT) n = mbps_pkg::PAT_LIMIT;
		return n;
	endfunction

	// Advance the scan state by one byte and return the result it should produce.
	function automatic scan_result_t scan_byte(input logic [7:0] b, input logic is_start,
	                                           input logic is_end);
		scan_result_t r;
		int n;
		int i;
		r = '0;
		n = active_length();
		if (is_start) begin
			for (i = 0; i < mbps_pkg::WIN_DEPTH; i++) win_bytes[i] = '0;
			byte_count = '0;
			match_flag = 1'b0;
			first_addr = '0;
		end
		for (i = mbps_pkg::WIN_DEPTH - 1; i > 0; i--) win_bytes[i] = win_bytes[i-1];
		win_bytes[0] = b;
		if (byte_count != {mbps_pkg::COUNT_BITS{1'b1}}) byte_count = byte_count + 1'b1;
		if (64'(byte_count) >= 64'(n)) begin
			r.hit = 1'b1;
			for (i = 0; i < n; i++) begin
				if (care_bits[i] && win_bytes[n-1-i] != pat_flat[i*8 +: 8]) r.hit = 1'b0;
			end
			if (r.hit) begin
				r.hit_address = base_reg + 64'(byte_count) - 64'(n);
				if (!match_flag) begin
					match_flag = 1'b1;
					first_addr = r.hit_address;
				end
			end
		end
		r.found = match_flag;
		r.first_address = first_addr;
		r.scan_done = is_end;
		return r;
	endfunction

	task automatic report_mismatch(input string field, input logic [63:0] got,
	                               input logic [63:0] want);
		$display("%0t: result %0d, %s: got %h, expected %h", $time, results_seen, field, got,
		         want);
		mismatches++;
	endtask

	// Register write; the mirror follows at the edge that the block takes it.
	task automatic write_reg(input mbps_pkg::cfg_reg_t idx, input logic [63:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			mbps_pkg::REG_PATTERN_0: pat_flat[63:0] = value;
			mbps_pkg::REG_PATTERN_1: pat_flat[127:64] = value;
			mbps_pkg::REG_PATTERN_2: pat_flat[191:128] = value;
			mbps_pkg::REG_PATTERN_3: pat_flat[255:192] = value;
			mbps_pkg::REG_CARE_MASK: care_bits = value[mbps_pkg::MASK_W-1:0];
			mbps_pkg::REG_PATTERN_LENGTH: len_reg = value[mbps_pkg::LEN_W-1:0];
			mbps_pkg::REG_BASE_ADDRESS: base_reg = value;
			default: ;
		endcase
	endtask

	task automatic push_item(input logic [7:0] b, input logic is_start, input logic is_end);
		scan_item_t it;
		it.data_byte = b;
		it.region_start = is_start;
		it.region_end = is_end;
		byte_queue = {byte_queue, it};
		bytes_queued++;
	endtask

	// Wait until every byte has been sent and every result has come back.
	task automatic wait_idle();
		while (bytes_sent != bytes_queued || predicted_results.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Queue one region of random bytes with copies of the pattern planted in it.
	task automatic add_region(input int n_bytes, input bit with_start, input bit with_end);
		logic [7:0] region_bytes[$];
		int n;
		int plants;
		int o;
		int j;
		int k;
		n = active_length();
		for (k = 0; k < n_bytes; k++) begin
			j = $urandom_range(0, n - 1);
			if ($urandom_range(0, 1) != 0) region_bytes = {region_bytes, pat_flat[j*8 +: 8]};
			else region_bytes = {region_bytes, 8'($urandom)};
		end
		if (n_bytes >= n) begin
			plants = $urandom_range(0, 1 + n_bytes / (n + 2));
			for (k = 0; k < plants; k++) begin
				o = $urandom_range(0, n_bytes - n);
				for (j = 0; j < n; j++) begin
					if (care_bits[j]) region_bytes[o+j] = pat_flat[j*8 +: 8];
				end
			end
		end
		for (k = 0; k < n_bytes; k++)
			push_item(region_bytes[k], with_start && k == 0, with_end && k == n_bytes - 1);
	endtask

	// Random settings, with the extremes placed in particular phases.
	task automatic configure_phase(input int k);
		logic [63:0] w;
		logic [31:0] m;
		logic [5:0]  l;
		logic [63:0] a;
		case (k)
			0: begin l = 6'd1;  m = $urandom; a = '0; end
			1: begin l = 6'd32; m = '1; a = '1; end
			2: begin l = 6'($urandom_range(2, 8)); m = $urandom; a = {$urandom, $urandom}; end
			3: begin l = 6'd63; m = $urandom & $urandom & $urandom; a = {$urandom, $urandom}; end
			4: begin l = 6'd33; m = '0; a = {$urandom, $urandom}; end
			5: begin l = 6'($urandom_range(3, 6)); m = $urandom; a = {$urandom, $urandom}; end
			default: begin
				l = 6'($urandom_range(1, 32));
				m = $urandom;
				a = 64'hFFFF_FFFF_FFFF_FFF0 | 64'($urandom_range(0, 15));
			end
		endcase
		w = (k == 1) ? '1 : (k == 5) ? '0 : {$urandom, $urandom};
		write_reg(mbps_pkg::REG_PATTERN_0, w);
		w = (k == 1) ? '1 : (k == 5) ? '0 : {$urandom, $urandom};
		write_reg(mbps_pkg::REG_PATTERN_1, w);
		w = (k == 1) ? '1 : (k == 5) ? '0 : {$urandom, $urandom};
		write_reg(mbps_pkg::REG_PATTERN_2, w);
		w = (k == 1) ? '1 : (k == 5) ? '0 : {$urandom, $urandom};
		write_reg(mbps_pkg::REG_PATTERN_3, w);
		write_reg(mbps_pkg::REG_CARE_MASK, 64'(m));
		write_reg(mbps_pkg::REG_PATTERN_LENGTH, 64'(l));
		write_reg(mbps_pkg::REG_BASE_ADDRESS, a);
		settings_used++;
	endtask

	// Sender: offers queued bytes and predicts the result of each accepted transfer.
	always @(posedge clk or negedge arst_n) begin : byte_sender
		scan_item_t nxt;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= 1'b0;
			s_axis_tlast <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				predicted_results = {predicted_results,
				                     scan_byte(s_axis_tdata, s_axis_tuser, s_axis_tlast)};
				bytes_sent++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (byte_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					nxt = byte_queue.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= nxt.data_byte;
					s_axis_tuser <= nxt.region_start;
					s_axis_tlast <= nxt.region_end;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each result transfer and drives tready, including one long hold-off.
	always @(posedge clk or negedge arst_n) begin : result_checker
		scan_result_t want;
		int hold_left;
		bit hold_used;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_left = 0;
			hold_used = 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen++;
				if (predicted_results.size() == 0) begin
					report_mismatch("result with nothing expected", m_axis_tdata[63:0], '0);
				end else begin
					want = predicted_results.pop_front();
					if (want.hit) hits_seen++;
					if (m_axis_tuser[0] !== want.hit)
						report_mismatch("hit", 64'(m_axis_tuser[0]), 64'(want.hit));
					if (m_axis_tdata[63:0] !== want.hit_address)
						report_mismatch("hit_address", m_axis_tdata[63:0], want.hit_address);
					if (m_axis_tuser[1] !== want.found)
						report_mismatch("found", 64'(m_axis_tuser[1]), 64'(want.found));
					if (m_axis_tdata[127:64] !== want.first_address)
						report_mismatch("first_address", m_axis_tdata[127:64],
						                want.first_address);
					if (m_axis_tlast !== want.scan_done)
						report_mismatch("scan_done", 64'(m_axis_tlast), 64'(want.scan_done));
				end
			end
			if (hold_left != 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (hold_arm && !hold_used) begin
				hold_used = 1'b1;
				hold_left = HOLD_CYCLES;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// Watchdog on cycles without any transfer or register write.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
				$display("masked_byte_pattern_search_unit_tb: FAIL");
				$finish;
			end
		end
	end

	// Stimulus sequence.
	initial begin : stimulus
		int k;
		int phase_start;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset settings, empty care mask with a match at address zero,
		// bytes after a region end continuing without a new start.
		send_idle_pct = 31;
		recv_idle_pct = 69;
		settings_used++;
		push_item(8'h00, 1'b1, 1'b0);
		push_item(8'hFF, 1'b0, 1'b0);
		push_item(8'h5A, 1'b0, 1'b1);
		push_item(8'h11, 1'b0, 1'b0);
		wait_idle();

		// Directed: length four with one wildcard, too few bytes at the start,
		// and a second match whose address wraps past the top of the space.
		write_reg(mbps_pkg::REG_PATTERN_0, 64'h1122_3344_EF5A_BEAD);
		write_reg(mbps_pkg::REG_PATTERN_1, '0);
		write_reg(mbps_pkg::REG_PATTERN_2, '0);
		write_reg(mbps_pkg::REG_PATTERN_3, '0);
		write_reg(mbps_pkg::REG_CARE_MASK, 64'h0000_000B);
		write_reg(mbps_pkg::REG_PATTERN_LENGTH, 64'd4);
		write_reg(mbps_pkg::REG_BASE_ADDRESS, 64'hFFFF_FFFF_FFFF_FFFE);
		settings_used++;
		push_item(8'hAD, 1'b1, 1'b0);
		push_item(8'hBE, 1'b0, 1'b0);
		push_item(8'h00, 1'b0, 1'b0);
		push_item(8'hEF, 1'b0, 1'b0);
		push_item(8'hAD, 1'b0, 1'b0);
		push_item(8'hBE, 1'b0, 1'b0);
		push_item(8'hFF, 1'b0, 1'b0);
		push_item(8'hEF, 1'b0, 1'b0);
		push_item(8'h00, 1'b0, 1'b1);
		wait_idle();

		// Directed: a length of zero compares a single byte.
		write_reg(mbps_pkg::REG_PATTERN_0, 64'h0000_0000_0000_007E);
		write_reg(mbps_pkg::REG_CARE_MASK, 64'h0000_0001);
		write_reg(mbps_pkg::REG_PATTERN_LENGTH, 64'd0);
		settings_used++;
		push_item(8'h7E, 1'b1, 1'b0);
		push_item(8'h00, 1'b0, 1'b0);
		push_item(8'h7E, 1'b0, 1'b1);
		push_item(8'h7E, 1'b0, 1'b0);
		wait_idle();

		// Random phases: mostly whole regions with planted matches, some stray bytes.
		for (k = 0; k < RANDOM_PHASES; k++) begin
			send_idle_pct = (k < 2) ? 31 : (k < 4) ? 69 : 0;
			recv_idle_pct = (k < 2) ? 69 : (k < 4) ? 31 : 0;
			configure_phase(k);
			if (k == 4) hold_arm = 1'b1;
			phase_start = bytes_queued;
			while (bytes_queued - phase_start < PHASE_ITEMS) begin
				if ($urandom_range(0, 99) < 8)
					push_item(8'($urandom), $urandom_range(0, 3) == 0,
					          $urandom_range(0, 3) == 0);
				else
					add_region(active_length() + $urandom_range(0, 24),
					           $urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0);
			end
			wait_idle();
		end

		repeat (5) @(posedge clk);
		$display("Covered %0d byte transfers and %0d results (%0d hits) under %0d settings,",
		         bytes_sent, results_seen, hits_seen, settings_used);
		$display("including wildcards, clipped and zero lengths, address wrap and a long stall.");
		if (mismatches == 0 && predicted_results.size() == 0) begin
			$display("masked_byte_pattern_search_unit_tb: PASS");
		end else begin
			$display("masked_byte_pattern_search_unit_tb: FAIL");
		end
		$finish;
	end

endmodule
